FILE: hdl/spacewire_tcp_frame_deframer_macros.svh
// Assertion macros for the frame deframer checker.
`ifndef SPACEWIRE_TCP_FRAME_DEFRAMER_MACROS_SVH
`define SPACEWIRE_TCP_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define STDFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STDFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/stdfr_pkg.sv
// Types and constants shared by the frame deframer modules.
`default_nettype none

package stdfr_pkg;

   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned LEN_W        = 25;

   localparam logic [LEN_W-1:0] CAPACITY_RESET = 25'd65536;

   // Header byte positions
   localparam logic [3:0] POS_TYPE      = 4'd0;
   localparam logic [3:0] POS_RSV       = 4'd1;
   localparam logic [3:0] POS_EXT_HI    = 4'd2;
   localparam logic [3:0] POS_EXT_LO    = 4'd3;
   localparam logic [3:0] POS_LEN_FIRST = 4'd4;
   localparam logic [3:0] POS_LAST      = 4'(HEADER_BYTES - 1);

   // Frame types
   localparam logic [7:0] TYPE_FINAL    = 8'h00;
   localparam logic [7:0] TYPE_DROPPED  = 8'h01;
   localparam logic [7:0] TYPE_CONT     = 8'h02;
   localparam logic [7:0] TYPE_TIMECODE = 8'h31;

   // Last timecode header byte
   localparam logic [7:0] TC_LAST_BYTE  = 8'h02;

   // Result kinds
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_BAD_MSG  = 2'd1;
   localparam logic [1:0] KIND_NO_SPACE = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_PAYLOAD = 3'd1,
      PH_DISCARD = 3'd2,
      PH_TC0     = 3'd3,
      PH_TC1     = 3'd4
   } phase_type;

   // Byte held in the input register, offered to the parser
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } item_type;

endpackage

`default_nettype wire

FILE: hdl/stdfr_in_stage.sv
// Input register stage of the frame deframer.
`default_nettype none

module stdfr_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_rx_byte,
   output stdfr_pkg::item_type    item,
   input  wire logic              take
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

`default_nettype wire

FILE: hdl/stdfr_parser.sv
// Frame header parser, payload counter and result register.
`default_nettype none

module stdfr_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire stdfr_pkg::item_type           item,
   output logic                               take,
   input  wire logic                          csr_wr_en,
   input  wire logic [stdfr_pkg::LEN_W-1:0]   csr_wr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic                               rsp_last,
   output logic [stdfr_pkg::LEN_W-1:0]        rsp_packet_length
);

   localparam int unsigned LW = stdfr_pkg::LEN_W;

   stdfr_pkg::phase_type phase_ff, phase_in, phase_next;
   logic [3:0]    pos_ff, pos_in;
   logic [7:0]    type_ff, type_in;
   logic          rsv_ff, rsv_in;
   logic [15:0]   ext_ff, ext_in;
   logic [63:0]   len_ff, len_in;
   logic          tc_ok_ff, tc_ok_in;
   logic [LW-1:0] left_ff, left_in, left_dec;
   logic [LW-1:0] room_ff, room_in;
   logic [LW-1:0] coll_ff, coll_in, coll_inc;
   logic [LW-1:0] cap_ff;

   // header byte updates and checks
   logic [7:0]    h_type;
   logic          h_rsv;
   logic [15:0]   h_ext;
   logic [63:0]   h_len;
   logic          h_tc_ok;
   logic [LW-1:0] h_room;
   logic          h_done;
   logic          h_err;
   logic [1:0]    h_kind;
   logic          type_known;

   logic [7:0]    b;

   // result
   logic          res_valid;
   logic [1:0]    res_kind;
   logic [7:0]    res_data;
   logic          res_last;
   logic [LW-1:0] res_len;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_kind_ff;
   logic [7:0]    out_data_ff;
   logic          out_last_ff;
   logic [LW-1:0] out_len_ff;

   assign b    = item.rx_byte;
   assign take = item.valid && (!out_valid_ff || rsp_ready);

   assign left_dec = left_ff - LW'(left_ff != '0);
   assign coll_inc = coll_ff + LW'(1);

   // Header field accumulation, using the current byte
   always_comb begin
      h_type  = type_ff;
      h_rsv   = rsv_ff;
      h_ext   = ext_ff;
      h_len   = len_ff;
      h_tc_ok = tc_ok_ff;
      h_room  = room_ff;
      priority if (pos_ff == stdfr_pkg::POS_TYPE) begin
         h_type  = b;
         h_rsv   = 1'b0;
         h_ext   = '0;
         h_len   = '0;
         h_tc_ok = 1'b1;
         if (coll_ff == '0) begin
            h_room = cap_ff;
         end
      end else if (pos_ff == stdfr_pkg::POS_RSV) begin
         h_rsv = (b != 8'd0);
      end else if (pos_ff < stdfr_pkg::POS_LEN_FIRST) begin
         h_ext = {ext_ff[7:0], b};
      end else begin
         h_len = {len_ff[55:0], b};
      end
      if (pos_ff >= stdfr_pkg::POS_EXT_HI && pos_ff < stdfr_pkg::POS_LAST && b != 8'd0) begin
         h_tc_ok = 1'b0;
      end
      if (pos_ff == stdfr_pkg::POS_LAST && b != stdfr_pkg::TC_LAST_BYTE) begin
         h_tc_ok = 1'b0;
      end
   end

   assign h_done     = (pos_ff >= stdfr_pkg::POS_LAST);
   assign type_known = (h_type == stdfr_pkg::TYPE_FINAL)   ||
                       (h_type == stdfr_pkg::TYPE_DROPPED) ||
                       (h_type == stdfr_pkg::TYPE_CONT)    ||
                       (h_type == stdfr_pkg::TYPE_TIMECODE);

   // Header verdict, checks in order
   always_comb begin
      h_err  = 1'b1;
      h_kind = stdfr_pkg::KIND_BAD_MSG;
      priority if (!type_known) begin
         h_kind = stdfr_pkg::KIND_BAD_MSG;
      end else if (h_rsv) begin
         h_kind = stdfr_pkg::KIND_BAD_MSG;
      end else if (h_ext != '0 || h_len > {{(64-LW){1'b0}}, room_ff}) begin
         h_kind = stdfr_pkg::KIND_NO_SPACE;
      end else if (h_len == '0) begin
         h_kind = stdfr_pkg::KIND_BAD_MSG;
      end else if (h_type == stdfr_pkg::TYPE_TIMECODE && !h_tc_ok) begin
         h_kind = stdfr_pkg::KIND_BAD_MSG;
      end else begin
         h_err = 1'b0;
      end
   end

   // Next phase
   always_comb begin
      phase_next = stdfr_pkg::PH_HEADER;
      unique case (phase_ff)
         stdfr_pkg::PH_HEADER: begin
            if (h_done && !h_err) begin
               priority if (h_type == stdfr_pkg::TYPE_TIMECODE) begin
                  phase_next = stdfr_pkg::PH_TC0;
               end else if (h_type == stdfr_pkg::TYPE_DROPPED) begin
                  phase_next = stdfr_pkg::PH_DISCARD;
               end else begin
                  phase_next = stdfr_pkg::PH_PAYLOAD;
               end
            end
         end
         stdfr_pkg::PH_PAYLOAD: begin
            phase_next = (left_dec == '0) ? stdfr_pkg::PH_HEADER : stdfr_pkg::PH_PAYLOAD;
         end
         stdfr_pkg::PH_DISCARD: begin
            phase_next = (left_dec == '0) ? stdfr_pkg::PH_HEADER : stdfr_pkg::PH_DISCARD;
         end
         stdfr_pkg::PH_TC0: begin
            phase_next = stdfr_pkg::PH_TC1;
         end
         stdfr_pkg::PH_TC1: begin
            phase_next = stdfr_pkg::PH_HEADER;
         end
         default: begin
            phase_next = stdfr_pkg::PH_HEADER;
         end
      endcase
   end

   assign phase_in = take ? phase_next : phase_ff;

   // Datapath updates and result
   always_comb begin
      pos_in    = pos_ff;
      type_in   = type_ff;
      rsv_in    = rsv_ff;
      ext_in    = ext_ff;
      len_in    = len_ff;
      tc_ok_in  = tc_ok_ff;
      left_in   = left_ff;
      room_in   = room_ff;
      coll_in   = coll_ff;
      res_valid = 1'b0;
      res_kind  = stdfr_pkg::KIND_DATA;
      res_data  = '0;
      res_last  = 1'b0;
      res_len   = '0;
      unique case (phase_ff)
         stdfr_pkg::PH_HEADER: begin
            type_in  = h_type;
            rsv_in   = h_rsv;
            ext_in   = h_ext;
            len_in   = h_len;
            tc_ok_in = h_tc_ok;
            room_in  = h_room;
            if (h_done) begin
               pos_in = '0;
               if (h_err) begin
                  coll_in   = '0;
                  res_valid = 1'b1;
                  res_kind  = h_kind;
               end else begin
                  // length already checked against the room left, so it fits
                  left_in = h_len[LW-1:0];
               end
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
         stdfr_pkg::PH_PAYLOAD: begin
            left_in   = left_dec;
            room_in   = room_ff - LW'(room_ff != '0);
            coll_in   = coll_inc;
            res_valid = 1'b1;
            res_data  = b;
            if (left_dec == '0) begin
               pos_in = '0;
               if (type_ff == stdfr_pkg::TYPE_FINAL) begin
                  coll_in  = '0;
                  res_last = 1'b1;
                  res_len  = coll_inc;
               end
            end
         end
         stdfr_pkg::PH_DISCARD: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               pos_in    = '0;
               coll_in   = '0;
               res_valid = 1'b1;
               res_kind  = stdfr_pkg::KIND_BAD_MSG;
            end
         end
         stdfr_pkg::PH_TC0: begin
         end
         stdfr_pkg::PH_TC1: begin
            pos_in = '0;
            if (b != 8'd0) begin
               coll_in   = '0;
               res_valid = 1'b1;
               res_kind  = stdfr_pkg::KIND_BAD_MSG;
            end
         end
         default: begin
            pos_in  = '0;
            coll_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= stdfr_pkg::PH_HEADER;
         pos_ff   <= '0;
         type_ff  <= '0;
         rsv_ff   <= 1'b0;
         ext_ff   <= '0;
         len_ff   <= '0;
         tc_ok_ff <= 1'b1;
         left_ff  <= '0;
         room_ff  <= '0;
         coll_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         if (take) begin
            pos_ff   <= pos_in;
            type_ff  <= type_in;
            rsv_ff   <= rsv_in;
            ext_ff   <= ext_in;
            len_ff   <= len_in;
            tc_ok_ff <= tc_ok_in;
            left_ff  <= left_in;
            room_ff  <= room_in;
            coll_ff  <= coll_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= stdfr_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Result register
   assign out_valid_in = take ? res_valid : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_kind_ff <= res_kind;
         out_data_ff <= res_data;
         out_last_ff <= res_last;
         out_len_ff  <= res_len;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_packet_length = out_len_ff;

endmodule

`default_nettype wire

FILE: hdl/spacewire_tcp_frame_deframer.sv
// A req byte goes through the input register, then the parser into the result reg, to its rsp.
// One stream byte per cycle while no held rsp stalls; a byte with no result is still taken.
// The result register is held while rsp_ready is low and a new byte waits in the input register.
// Synchronous active-high reset: parser returns to the start of a header, no rsp pending,
// buffer capacity returns to 65536 bytes.
`default_nettype none

module spacewire_tcp_frame_deframer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // stream byte input
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_rx_byte,
   // result output
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_kind,
   output logic [7:0]                       rsp_data_byte,
   output logic                             rsp_last,
   output logic [stdfr_pkg::LEN_W-1:0]      rsp_packet_length,
   // buffer capacity register
   input  wire logic                        csr_wr_en,
   input  wire logic [stdfr_pkg::LEN_W-1:0] csr_wr_data
);

   // Byte handed from the input register to the parser; take marks its transfer
   stdfr_pkg::item_type item;
   logic                take;

   // Hold each accepted byte until taken; refill in the same cycle the parser drains it
   stdfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .item        (item),
      .take        (take)
   );

   // Strip headers, count payload against the remaining buffer space, drop timecodes,
   // and register at most one result per byte
   stdfr_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .item              (item),
      .take              (take),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last          (rsp_last),
      .rsp_packet_length (rsp_packet_length)
   );

endmodule

`default_nettype wire

FILE: hdl/stdfr_checker.sv
// Port-level checker for the frame deframer, bound to the top level.
`default_nettype none
`include "spacewire_tcp_frame_deframer_macros.svh"

module stdfr_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [1:0]                  rsp_kind,
   input wire logic [7:0]                  rsp_data_byte,
   input wire logic                        rsp_last,
   input wire logic [stdfr_pkg::LEN_W-1:0] rsp_packet_length
);

   `STDFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_last) && $stable(rsp_packet_length), "rsp changed while stalled")
   `STDFR_ASSERT_NOW(a_err_clean, clock, reset, rsp_valid && rsp_kind != stdfr_pkg::KIND_DATA, rsp_data_byte == 8'd0 && !rsp_last && rsp_packet_length == '0, "error result carries payload")
   `STDFR_ASSERT_NOW(a_len_last, clock, reset, rsp_valid && rsp_kind == stdfr_pkg::KIND_DATA, rsp_last == (rsp_packet_length != '0), "packet length and last disagree")
   `STDFR_ASSERT_NOW(a_reset_idle, clock, reset, $past(reset), !rsp_valid, "rsp valid straight after reset")

endmodule

bind spacewire_tcp_frame_deframer stdfr_checker u_stdfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_last          (rsp_last),
   .rsp_packet_length (rsp_packet_length)
);

`default_nettype wire

FILE: dv/tb_spacewire_tcp_frame_deframer.sv
// Self-checking testbench for the SpaceWire-over-TCP frame deframer.
`default_nettype none

module tb_spacewire_tcp_frame_deframer;
   import stdfr_pkg::*;

   // One result as it leaves the block
   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data_byte;
      logic             last;
      logic [LEN_W-1:0] packet_length;
   } deframed_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_kind;
   logic [7:0]       rsp_data_byte;
   logic             rsp_last;
   logic [LEN_W-1:0] rsp_packet_length;
   logic             csr_wr_en = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;

   spacewire_tcp_frame_deframer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last          (rsp_last),
      .rsp_packet_length (rsp_packet_length),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Stream bytes waiting to be offered, and results the parser is due to give
   logic [7:0]    stream_q [$];
   deframed_type  deframed_q [$];
   deframed_type  want_rsp;

   // Idling mix of the current phase, in percent
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int mismatch_count = 0;
   int bytes_accepted = 0;
   int results_seen   = 0;
   int packets_done   = 0;
   int bad_msg_seen   = 0;
   int no_space_seen  = 0;

   logic [LEN_W-1:0] cap_steps [8] = '{25'd0, 25'h1000000, 25'd1, 25'd6,
                                       25'd33, 25'd300, 25'd65536, 25'd12};

   // ---------------------------------------------------------------------
   // Parser state mirrored on the testbench side
   // ---------------------------------------------------------------------
   logic [LEN_W-1:0] buffer_cap    = CAPACITY_RESET;
   phase_type        parse_phase   = PH_HEADER;
   logic [3:0]       hdr_pos       = 4'd0;
   logic [7:0]       frame_type    = 8'h00;
   logic             rsv_nonzero   = 1'b0;
   logic [15:0]      ext_len       = 16'h0000;
   logic [63:0]      frame_left    = 64'd0;   // frame bytes still to come
   logic             tc_pattern_ok = 1'b1;
   logic [LEN_W-1:0] space_left    = '0;
   logic [LEN_W-1:0] collected     = '0;

   task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
                                input logic last, input logic [LEN_W-1:0] len);
      deframed_type r;
      r.kind          = kind;
      r.data_byte     = data;
      r.last          = last;
      r.packet_length = len;
      deframed_q.push_back(r);
   endtask

   // Report an error and restart at a fresh header with an empty packet
   task automatic flag_error(input logic [1:0] kind);
      expect_result(kind, 8'h00, 1'b0, '0);
      parse_phase = PH_HEADER;
      hdr_pos     = POS_TYPE;
      collected   = '0;
   endtask

   // Advance the mirrored parser by one stream byte
   task automatic deframe_byte(input logic [7:0] b);
      logic [3:0] p;
      p = hdr_pos;
      case (parse_phase)
         PH_HEADER: begin
            if (p == POS_TYPE) begin
               frame_type    = b;
               rsv_nonzero   = 1'b0;
               ext_len       = 16'h0000;
               frame_left    = 64'd0;
               tc_pattern_ok = 1'b1;
               // sample the capacity only when a new packet begins
               if (collected == '0)
                  space_left = buffer_cap;
            end else if (p == POS_RSV) begin
               rsv_nonzero = (b != 8'h00);
            end else if (p <= POS_EXT_LO) begin
               ext_len = {ext_len[7:0], b};
            end else begin
               frame_left = {frame_left[55:0], b};
            end
            if (p >= POS_EXT_HI && p < POS_LAST && b != 8'h00)
               tc_pattern_ok = 1'b0;
            if (p == POS_LAST && b != TC_LAST_BYTE)
               tc_pattern_ok = 1'b0;
            if (p != POS_LAST) begin
               hdr_pos = p + 4'd1;
            end else if (frame_type != TYPE_FINAL && frame_type != TYPE_DROPPED &&
                         frame_type != TYPE_CONT && frame_type != TYPE_TIMECODE) begin
               flag_error(KIND_BAD_MSG);
            end else if (rsv_nonzero) begin
               flag_error(KIND_BAD_MSG);
            end else if (ext_len != 16'h0000 || frame_left > {39'd0, space_left}) begin
               flag_error(KIND_NO_SPACE);
            end else if (frame_left == 64'd0) begin
               flag_error(KIND_BAD_MSG);
            end else if (frame_type == TYPE_TIMECODE && !tc_pattern_ok) begin
               flag_error(KIND_BAD_MSG);
            end else begin
               hdr_pos = POS_TYPE;
               if (frame_type == TYPE_TIMECODE)
                  parse_phase = PH_TC0;
               else if (frame_type == TYPE_DROPPED)
                  parse_phase = PH_DISCARD;
               else
                  parse_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            collected = collected + 1'b1;
            if (space_left != '0)
               space_left = space_left - 1'b1;
            if (frame_left != 64'd0)
               frame_left = frame_left - 64'd1;
            if (frame_left == 64'd0) begin
               parse_phase = PH_HEADER;
               hdr_pos     = POS_TYPE;
            end
            if (frame_left == 64'd0 && frame_type == TYPE_FINAL) begin
               expect_result(KIND_DATA, b, 1'b1, collected);
               collected = '0;
            end else begin
               expect_result(KIND_DATA, b, 1'b0, '0);
            end
         end
         PH_DISCARD: begin
            if (frame_left != 64'd0)
               frame_left = frame_left - 64'd1;
            if (frame_left == 64'd0)
               flag_error(KIND_BAD_MSG);
         end
         PH_TC0: begin
            parse_phase = PH_TC1;
         end
         PH_TC1: begin
            if (b != 8'h00) begin
               flag_error(KIND_BAD_MSG);
            end else begin
               parse_phase = PH_HEADER;
               hdr_pos     = POS_TYPE;
            end
         end
         default: begin
            parse_phase = PH_HEADER;
            hdr_pos     = POS_TYPE;
            collected   = '0;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stream building
   // ---------------------------------------------------------------------
   task automatic queue_header(input logic [7:0] ftype, input logic [7:0] rsv,
                               input logic [15:0] ext, input logic [63:0] len);
      stream_q.push_back(ftype);
      stream_q.push_back(rsv);
      stream_q.push_back(ext[15:8]);
      stream_q.push_back(ext[7:0]);
      // payload length goes out big-endian
      for (int i = 7; i >= 0; i--)
         stream_q.push_back(len[i*8 +: 8]);
   endtask

   task automatic queue_body(input int n);
      repeat (n) stream_q.push_back(8'($urandom));
   endtask

   // A packet of one to three fragments, sometimes with a timecode in between
   // or a dropped frame that kills it. Stop at the first header the parser
   // rejects, so that the stream never falls out of step with the frames.
   task automatic queue_packet(input logic [LEN_W-1:0] cap);
      logic [63:0] space;
      logic [7:0]  ftype;
      int          nfrag;
      int          len;
      int          pick;
      space = {39'd0, cap};
      nfrag = $urandom_range(1, 3);
      for (int i = 0; i < nfrag; i++) begin
         if ($urandom_range(9) == 0) begin
            queue_header(TYPE_TIMECODE, 8'h00, 16'h0000, 64'd2);
            if (space < 64'd2)
               return;
            stream_q.push_back(8'($urandom));
            stream_q.push_back(8'h00);
         end
         pick = $urandom_range(99);
         if (pick < 70)
            len = $urandom_range(1, 6);
         else if (pick < 95)
            len = $urandom_range(7, 40);
         else
            len = $urandom_range(41, 300);
         ftype = (i == nfrag - 1) ? TYPE_FINAL : TYPE_CONT;
         if ($urandom_range(19) == 0)
            ftype = TYPE_DROPPED;
         queue_header(ftype, 8'h00, 16'h0000, 64'(len));
         if (64'(len) > space)
            return;
         queue_body(len);
         if (ftype == TYPE_DROPPED)
            return;
         space = space - 64'(len);
      end
   endtask

   // Mostly well-formed packets; the rest is noise and broken frames
   task automatic queue_random_sequence(input logic [LEN_W-1:0] cap);
      int         pick;
      logic [7:0] bad_type;
      pick = $urandom_range(99);
      if (pick < 78) begin
         queue_packet(cap);
      end else if (pick < 84) begin
         queue_header(TYPE_TIMECODE, 8'h00, 16'h0000, 64'd2);
         if (cap >= 2) begin
            stream_q.push_back(8'($urandom));
            stream_q.push_back(8'h00);
         end
      end else if (pick < 88) begin
         // random header; a nonzero reserved byte makes sure it is rejected
         stream_q.push_back(8'($urandom));
         stream_q.push_back(8'($urandom_range(1, 255)));
         queue_body(10);
      end else if (pick < 96) begin
         case ($urandom_range(5))
            0: begin
               bad_type = 8'($urandom);
               if (bad_type == TYPE_FINAL || bad_type == TYPE_DROPPED ||
                   bad_type == TYPE_CONT || bad_type == TYPE_TIMECODE)
                  bad_type = 8'hC5;
               queue_header(bad_type, 8'h00, 16'h0000, 64'($urandom_range(1, 6)));
            end
            1: queue_header(TYPE_FINAL, 8'($urandom_range(1, 255)), 16'h0000,
                            64'($urandom_range(1, 6)));
            2: queue_header(TYPE_CONT, 8'h00, 16'($urandom_range(1, 65535)), 64'd1);
            3: queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd0);
            4: queue_header(TYPE_FINAL, 8'h00, 16'h0000,
                            {32'($urandom) | 32'h1, 32'($urandom)});
            default: queue_header(TYPE_TIMECODE, 8'h00, 16'h0000,
                                  ($urandom_range(1) != 0) ? 64'd3 : 64'd1);
         endcase
      end else begin
         // timecode whose second body byte is not zero
         queue_header(TYPE_TIMECODE, 8'h00, 16'h0000, 64'd2);
         if (cap >= 2) begin
            stream_q.push_back(8'($urandom));
            stream_q.push_back(8'($urandom_range(1, 255)));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
               results_seen, what, got, want);
      mismatch_count++;
   endtask

   // Driver: hold the byte until its transfer, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= stream_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               report_mismatch("unexpected result, kind", 64'(rsp_kind), 64'd0);
            end else begin
               want_rsp = deframed_q.pop_front();
               if (rsp_kind != want_rsp.kind)
                  report_mismatch("kind", 64'(rsp_kind), 64'(want_rsp.kind));
               if (rsp_data_byte != want_rsp.data_byte)
                  report_mismatch("data_byte", 64'(rsp_data_byte), 64'(want_rsp.data_byte));
               if (rsp_last != want_rsp.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want_rsp.last));
               if (rsp_packet_length != want_rsp.packet_length)
                  report_mismatch("packet_length", 64'(rsp_packet_length),
                                  64'(want_rsp.packet_length));
            end
            results_seen++;
            if (rsp_kind == KIND_DATA && rsp_last)
               packets_done++;
            if (rsp_kind == KIND_BAD_MSG)
               bad_msg_seen++;
            if (rsp_kind == KIND_NO_SPACE)
               no_space_seen++;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------

   // Hold until every byte has gone in and every result has come out, then let
   // the pipeline settle: a byte that gives no result may still be in flight.
   task automatic wait_until_idle();
      while (stream_q.size() != 0 || req_valid || deframed_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the capacity register; only ever called with the block idle
   task automatic write_capacity(input logic [LEN_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      buffer_cap = value;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset capacity of 65536 bytes, no idling.
      // Single-byte and three-byte final frames with extreme payload values.
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd1);
      stream_q.push_back(8'h00);
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd3);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h80);
      stream_q.push_back(8'h01);
      // continuation, good timecode mid-packet, then final: packet of four
      queue_header(TYPE_CONT, 8'h00, 16'h0000, 64'd2);
      queue_body(2);
      queue_header(TYPE_TIMECODE, 8'h00, 16'h0000, 64'd2);
      stream_q.push_back(8'h3F);
      stream_q.push_back(8'h00);
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd2);
      queue_body(2);
      // dropped frame: skip the payload, bad message on its last byte
      queue_header(TYPE_DROPPED, 8'h00, 16'h0000, 64'd3);
      queue_body(3);
      // unknown type, alone and together with a nonzero reserved byte
      queue_header(8'h07, 8'h00, 16'h0000, 64'd1);
      queue_header(8'hFF, 8'h01, 16'h0000, 64'd1);
      // reserved byte wins over extra length
      queue_header(TYPE_FINAL, 8'h80, 16'h0001, 64'd1);
      // extra length gives no space even when the payload length is zero
      queue_header(TYPE_CONT, 8'h00, 16'h8000, 64'd0);
      // payload lengths beyond the capacity
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd65537);
      // zero payload length
      queue_header(TYPE_DROPPED, 8'h00, 16'h0000, 64'd0);
      // timecode header with the wrong length pattern
      queue_header(TYPE_TIMECODE, 8'h00, 16'h0000, 64'd3);
      // timecode body with a nonzero second byte
      queue_header(TYPE_TIMECODE, 8'h00, 16'h0000, 64'd2);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h5A);
      // dropped frame in the middle of a packet kills it; the next one is fresh
      queue_header(TYPE_CONT, 8'h00, 16'h0000, 64'd1);
      queue_body(1);
      queue_header(TYPE_DROPPED, 8'h00, 16'h0000, 64'd1);
      queue_body(1);
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd2);
      queue_body(2);
      wait_until_idle();

      // Capacity written mid-packet takes effect only at the next packet:
      // the final fragment is still checked against the old remaining space.
      write_capacity(25'd10);
      queue_header(TYPE_CONT, 8'h00, 16'h0000, 64'd4);
      queue_body(4);
      wait_until_idle();
      write_capacity(25'd3);
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd6);
      queue_body(6);
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd4);
      queue_header(TYPE_FINAL, 8'h00, 16'h0000, 64'd3);
      queue_body(3);
      wait_until_idle();

      // Random phases: each capacity setting, cycling through the idling mixes
      for (int ph = 0; ph < 8; ph++) begin
         write_capacity(cap_steps[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 84; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         while (stream_q.size() < 170)
            queue_random_sequence(cap_steps[ph]);
         // drain fully before the next write: the sender pauses here
         wait_until_idle();
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      if (deframed_q.size() != 0)
         report_mismatch("results never delivered, count", 64'd0, 64'(deframed_q.size()));

      $display("Run covered %0d stream bytes under ten capacity settings (0 to 16777216)",
               bytes_accepted);
      $display("and four idling mixes: %0d results, %0d packets, %0d bad-message, %0d no-space",
               results_seen, packets_done, bad_msg_seen, no_space_seen);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: a correct run finishes far inside this
   initial begin
      #7200000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
